>>> hdl/bcc_pkg.sv
// Package with the types, codes and reset values shared by the button click classifier.
`default_nettype none
package bcc_pkg;

  localparam int unsigned TIME_W = 16;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } press_event_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE   = 2'd1,
    REG_LONG     = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_index_t;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [TIME_W-1:0] DOUBLE_RESET   = 16'd300;
  localparam logic [TIME_W-1:0] LONG_RESET     = 16'd1000;

  typedef struct packed {
    logic [TIME_W-1:0] debounce_ms;
    logic [TIME_W-1:0] double_window_ms;
    logic [TIME_W-1:0] long_press_ms;
  } bcc_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed_count;
    logic              timing_active;
    logic              previous_level;
    logic [TIME_W-1:0] change_stamp;
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] release_stamp;
    logic              second_click_wait;
    logic              long_armed;
    logic              long_reported;
  } bcc_state_t;

endpackage
`default_nettype wire

>>> hdl/bcc_in_if.sv
// Interface for the poll channel: valid, ready and one pin sample with its tick flag.
`default_nettype none
interface bcc_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic ms_tick;

  modport source (output valid, output pin_level, output ms_tick, input ready);
  modport sink (input valid, input pin_level, input ms_tick, output ready);
endinterface
`default_nettype wire

>>> hdl/bcc_out_if.sv
// Interface for the result channel: valid, ready and the classified press event.
`default_nettype none
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface
`default_nettype wire

>>> hdl/bcc_step.sv
// Next-state and event logic for one poll of the button click classifier.
`default_nettype none
module bcc_step (
  input  bcc_pkg::bcc_state_t   state_cur,
  input  bcc_pkg::bcc_cfg_t     cfg,
  input  logic                  pin_level,
  input  logic                  ms_tick,
  output bcc_pkg::bcc_state_t   state_next,
  output bcc_pkg::press_event_t press_event
);
  import bcc_pkg::*;

  // A stamp later than now reads as a gap beyond any 16-bit threshold.
  function automatic logic [TIME_W:0] since(input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] stamp);
    logic [TIME_W:0] diff;
    begin
      if (stamp > now) begin
        diff = {1'b1, {TIME_W{1'b0}}};
      end else begin
        diff = {1'b0, now - stamp};
      end
      return diff;
    end
  endfunction

  function automatic bcc_state_t clear_timer(input bcc_state_t s_in);
    bcc_state_t s_out;
    begin
      s_out                   = s_in;
      s_out.second_click_wait = 1'b0;
      s_out.timing_active     = 1'b0;
      s_out.elapsed_count     = '0;
      s_out.release_stamp     = '0;
      s_out.press_stamp       = '0;
      return s_out;
    end
  endfunction

  always_comb begin
    bcc_state_t        s;
    logic [TIME_W-1:0] now;
    logic              swallow;
    press_event_t      ev;

    s       = state_cur;
    ev      = EV_NONE;
    swallow = 1'b0;

    if (s.timing_active) begin
      s.elapsed_count = s.elapsed_count + TIME_W'(ms_tick);
      now = s.elapsed_count;
    end else begin
      s.elapsed_count = '0;
      now = '0;
    end

    if (pin_level != s.previous_level) begin
      s.change_stamp  = now;
      s.timing_active = 1'b1;
    end

    if (since(now, s.change_stamp) > {1'b0, cfg.debounce_ms}) begin
      if (pin_level && !s.long_armed) begin
        s.press_stamp = now;
        s.long_armed  = 1'b1;
      end else if (!pin_level && s.long_armed) begin
        if (s.long_reported) begin
          s.long_reported = 1'b0;
          s            = clear_timer(s);
          s.long_armed = 1'b0;
          swallow      = 1'b1;
        end else begin
          s.long_armed = 1'b0;
          if (s.second_click_wait &&
              since(now, s.release_stamp) < {1'b0, cfg.double_window_ms}) begin
            ev = EV_DOUBLE;
            s  = clear_timer(s);
          end else begin
            s.second_click_wait = 1'b1;
            s.release_stamp     = now;
          end
        end
      end
    end

    if (!swallow) begin
      if (s.second_click_wait &&
          since(now, s.release_stamp) > {1'b0, cfg.double_window_ms}) begin
        ev = EV_SINGLE;
        s  = clear_timer(s);
      end

      s.previous_level = pin_level;

      if (s.long_armed && pin_level &&
          since(now, s.press_stamp) >= {1'b0, cfg.long_press_ms}) begin
        s                = clear_timer(s);
        s.long_reported  = 1'b1;
        s.previous_level = 1'b0;
        s.long_armed     = 1'b0;
        ev               = EV_LONG;
      end
    end

    state_next  = s;
    press_event = ev;
  end

endmodule
`default_nettype wire

>>> hdl/button_click_classifier_core.sv
// Top level of the button click classifier: config registers, state and result register.
// A result is registered and is valid in the cycle after its poll item is accepted.
// Throughput: one item per cycle while results are taken; the only loop is the state update.
// The poll side is ready whenever the result register is empty or being taken.
// Reset clears all state and the result valid flag and loads default thresholds.
`default_nettype none
module button_click_classifier_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bcc_in_if.sink      poll,
  bcc_out_if.source   result
);
  import bcc_pkg::*;

  bcc_cfg_t     cfg;
  bcc_state_t   state;
  bcc_state_t   state_next;
  press_event_t step_event;
  press_event_t press_event;
  logic         result_valid;
  logic         poll_accept;

  bcc_step u_step (
    .state_cur   (state),
    .cfg         (cfg),
    .pin_level   (poll.pin_level),
    .ms_tick     (poll.ms_tick),
    .state_next  (state_next),
    .press_event (step_event)
  );

  assign poll.ready         = !result_valid || result.ready;
  assign poll_accept        = poll.valid && poll.ready;
  assign result.valid       = result_valid;
  assign result.press_event = press_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= DEBOUNCE_RESET;
      cfg.double_window_ms <= DOUBLE_RESET;
      cfg.long_press_ms    <= LONG_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE: cfg.debounce_ms      <= cfg_data;
        REG_DOUBLE:   cfg.double_window_ms <= cfg_data;
        REG_LONG:     cfg.long_press_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (poll_accept) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_accept) begin
      press_event <= step_event;
    end
  end

`ifndef SYNTH
  a_idle_timer_zero: assert property (@(posedge clk) disable iff (rst)
    !state.timing_active |-> state.elapsed_count == '0)
    else $error("elapsed count nonzero while timing is idle");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    poll_accept |=> result_valid)
    else $error("accepted item produced no result");

  a_long_sets_reported: assert property (@(posedge clk) disable iff (rst)
    poll_accept && step_event == EV_LONG |=> state.long_reported && !state.long_armed)
    else $error("long press did not mark long press done");

  a_click_clears_timer: assert property (@(posedge clk) disable iff (rst)
    poll_accept && (step_event == EV_SINGLE || step_event == EV_DOUBLE)
    |=> !state.second_click_wait && !state.timing_active)
    else $error("click event left timing running");
`endif

endmodule
`default_nettype wire

>>> dv/tb_button_click_classifier_core.sv
// Self-checking testbench for the button click classifier: directed and random polls against a predictor.
module tb_button_click_classifier_core;
  import bcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int MAX_REPORTS = 50;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bcc_in_if  poll_if();
  bcc_out_if result_if();

  button_click_classifier_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_if),
    .result    (result_if)
  );

  // Predictor copy of the thresholds and of the classifier state.
  logic [15:0] cfg_debounce = DEBOUNCE_RESET;
  logic [15:0] cfg_window   = DOUBLE_RESET;
  logic [15:0] cfg_long     = LONG_RESET;

  logic [15:0] tmr_count      = '0;
  logic        tmr_running    = 1'b0;
  logic        level_q        = 1'b0;
  logic [15:0] edge_time      = '0;
  logic [15:0] down_time      = '0;
  logic [15:0] up_time        = '0;
  logic        pending_single = 1'b0;
  logic        hold_armed     = 1'b0;
  logic        hold_fired     = 1'b0;

  press_event_t expected_events[$];

  int error_count = 0;
  int polls_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] gap(logic [15:0] now, logic [15:0] stamp);
    return (stamp > now) ? 17'h10000 : {1'b0, now - stamp};
  endfunction

  function automatic void stop_timer();
    pending_single = 1'b0;
    tmr_running = 1'b0;
    tmr_count = '0;
    up_time = '0;
    down_time = '0;
  endfunction

  function automatic press_event_t classify_poll(logic lvl, logic tk);
    logic [15:0] now;
    press_event_t ev;
    ev = EV_NONE;
    if (tmr_running) begin
      tmr_count = tmr_count + 16'(tk);
      now = tmr_count;
    end else begin
      tmr_count = '0;
      now = '0;
    end
    if (lvl != level_q) begin
      edge_time = now;
      tmr_running = 1'b1;
    end
    if (gap(now, edge_time) > {1'b0, cfg_debounce}) begin
      if (lvl && !hold_armed) begin
        down_time = now;
        hold_armed = 1'b1;
      end else if (!lvl && hold_armed) begin
        // The release that ends a long press reports nothing.
        if (hold_fired) begin
          hold_fired = 1'b0;
          stop_timer();
          hold_armed = 1'b0;
          return EV_NONE;
        end
        hold_armed = 1'b0;
        if (pending_single && gap(now, up_time) < {1'b0, cfg_window}) begin
          ev = EV_DOUBLE;
          stop_timer();
        end else begin
          pending_single = 1'b1;
          up_time = now;
        end
      end
    end
    if (pending_single && gap(now, up_time) > {1'b0, cfg_window}) begin
      ev = EV_SINGLE;
      stop_timer();
    end
    level_q = lvl;
    if (hold_armed && lvl && gap(now, down_time) >= {1'b0, cfg_long}) begin
      stop_timer();
      hold_fired = 1'b1;
      level_q = 1'b0;
      hold_armed = 1'b0;
      ev = EV_LONG;
    end
    return ev;
  endfunction

  always @(negedge clk) begin
    if (!rst && poll_if.valid && poll_if.ready) begin
      expected_events.push_back(classify_poll(poll_if.pin_level, poll_if.ms_tick));
    end
  end

  always @(negedge clk) begin
    press_event_t exp_ev;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: press event with none expected: expected none, actual %0d",
                   $time, result_if.press_event);
        end
      end else begin
        exp_ev = expected_events.pop_front();
        if (result_if.press_event !== exp_ev) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: press_event mismatch: expected %0d, actual %0d",
                     $time, exp_ev, result_if.press_event);
          end
        end
      end
    end
  end

  initial begin : result_ready_driver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : cycle_watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_poll(input logic lvl, input logic tk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      poll_if.valid <= 1'b0;
      @(posedge clk);
    end
    poll_if.valid <= 1'b1;
    poll_if.pin_level <= lvl;
    poll_if.ms_tick <= tk;
    @(negedge clk);
    while (!poll_if.ready) @(negedge clk);
    @(posedge clk);
    polls_sent++;
  endtask

  task automatic wait_for_results();
    poll_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = val;
      REG_DOUBLE:   cfg_window = val;
      REG_LONG:     cfg_long = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [15:0] win,
                            input logic [15:0] lng);
    wait_for_results();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DOUBLE, win);
    write_reg(REG_LONG, lng);
  endtask

  task automatic set_small_config();
    set_config(16'($urandom_range(0, 4)), 16'($urandom_range(0, 24)),
               16'($urandom_range(0, 30)));
  endtask

  // Holds one level until the given number of milliseconds has passed.
  task automatic hold_level(input logic lvl, input int unsigned ms);
    int unsigned ticks;
    logic tk;
    ticks = 0;
    do begin
      tk = ($urandom_range(0, 3) != 0);
      if (ticks >= ms) tk = 1'b0;
      send_poll(lvl, tk);
      ticks += tk;
    end while (ticks < ms);
  endtask

  task automatic random_gesture();
    int unsigned d;
    int unsigned w;
    int unsigned l;
    d = cfg_debounce;
    w = cfg_window;
    l = cfg_long;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        hold_level(1'b1, $urandom_range(d + 1, d + 2 + l / 2));
        hold_level(1'b0, $urandom_range(d + 1, d + w + 4));
      end
      3, 4, 5: begin
        hold_level(1'b1, $urandom_range(d + 1, d + 3));
        hold_level(1'b0, $urandom_range(d + 1, d + 1 + w / 2));
        hold_level(1'b1, $urandom_range(d + 1, d + 3));
        hold_level(1'b0, $urandom_range(d + 1, d + w + 4));
      end
      6, 7: begin
        hold_level(1'b1, d + 1 + l + $urandom_range(0, l + 3));
        hold_level(1'b0, $urandom_range(d + 1, d + w + 4));
      end
      8: begin
        repeat ($urandom_range(1, 6)) begin
          send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      default: begin
        hold_level(1'b1, $urandom_range(0, d));
        hold_level(1'b0, $urandom_range(0, d + 2));
      end
    endcase
  endtask

  task automatic test_default_thresholds();
    send_poll(1'b0, 1'b0);
    send_poll(1'b1, 1'b0);
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b1);
    send_poll(1'b0, 1'b1);
    send_poll(1'b0, 1'b0);
  endtask

  task automatic test_threshold_extremes();
    set_config(16'd0, 16'd0, 16'd0);
    send_poll(1'b1, 1'b0);
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b1);
    send_poll(1'b0, 1'b1);
    send_poll(1'b1, 1'b1);
    send_poll(1'b0, 1'b1);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    send_poll(1'b1, 1'b1);
    send_poll(1'b0, 1'b1);
    send_poll(1'b1, 1'b0);
    set_config(16'd1, 16'hFFFF, 16'd200);
    repeat (2) begin
      repeat (3) send_poll(1'b1, 1'b1);
      repeat (3) send_poll(1'b0, 1'b1);
    end
  endtask

  // A click clears the timer, so the stored level change stamp lies above the current time.
  task automatic test_stale_stamp();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    set_config(16'd1, 16'd2, 16'hFFFF);
    repeat (2) begin
      repeat (3) send_poll(1'b1, 1'b1);
      repeat (3) send_poll(1'b0, 1'b1);
      repeat (4) send_poll(1'b0, 1'b1);
      repeat (2) send_poll(1'b0, 1'b0);
    end
    set_config(16'd0, 16'd2, 16'd3);
    repeat (6) send_poll(1'b1, 1'b1);
    repeat (3) send_poll(1'b0, 1'b0);
    repeat (3) send_poll(1'b0, 1'b1);
  endtask

  task automatic test_random_clicks(input int send_pct, input int stall_pct, input int n_items);
    int target;
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
    set_small_config();
    target = polls_sent + n_items;
    while (polls_sent < target) random_gesture();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    set_small_config();
    hold_trigger <= hold_trigger + 1;
    repeat (6) random_gesture();
    wait_for_results();
    repeat (6) random_gesture();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= '0;
    poll_if.valid <= 1'b0;
    poll_if.pin_level <= 1'b0;
    poll_if.ms_tick <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_default_thresholds();
    test_threshold_extremes();
    test_stale_stamp();
    test_random_clicks(0, 0, 100);
    test_random_clicks(49, 0, 100);
    test_random_clicks(0, 49, 100);
    test_random_clicks(15, 15, 100);
    test_backpressure();

    wait_for_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
